// ===== rtl/core/pwgi_pkg.sv =====
// Shared types and constants for the gated-integral PID controller.
// No dependencies; used by every module in rtl/core.
package pwgi_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_GAIN_P    = 3'd1;
    localparam logic [2:0] REG_GAIN_I    = 3'd2;
    localparam logic [2:0] REG_GAIN_D    = 3'd3;
    localparam logic [2:0] REG_INT_LIMIT = 3'd4;
    localparam logic [2:0] REG_I_RANGE   = 3'd5;
    localparam logic [2:0] REG_ERR_BAND  = 3'd6;
    localparam logic [2:0] REG_D_TOL     = 3'd7;

    localparam int CFG_W   = 24;  // widest register
    localparam int GAIN_W  = 16;
    localparam int OPND_W  = 21;  // magnitude fed to the multiplier
    localparam int TERM_W  = 29;  // magnitude of a scaled term
    localparam int Q_FRAC  = 8;   // Q8.8 fraction bits

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PTERM,
        ST_DTERM,
        ST_ITERM,
        ST_SUM
    } t_state;

    typedef enum logic [1:0] {
        OP_P,
        OP_D,
        OP_I
    } t_op;

    typedef struct packed {
        logic ready;
        logic load_p;
        logic load_d;
        logic load_i;
        logic load_out;
        t_op  op;
    } t_ctrl;

    // Magnitude of a 22-bit two's complement value.
    function automatic logic [21:0] abs22(input logic signed [21:0] v);
        logic [21:0] r;
        r = v[21] ? 22'(-v) : 22'(v);
        return r;
    endfunction

endpackage

// ===== rtl/core/pwgi_mul.sv =====
// Shared unsigned multiplier with Q8.8 rescale for the PID controller.
// Depends on pwgi_pkg for widths.
module pwgi_mul (
    input  logic [pwgi_pkg::GAIN_W-1:0] i_gain,
    input  logic [pwgi_pkg::OPND_W-1:0] i_mag,
    output logic [pwgi_pkg::TERM_W-1:0] o_term_mag
);

    logic [pwgi_pkg::GAIN_W+pwgi_pkg::OPND_W-1:0] prod;

    // Scaling the magnitude truncates toward zero once the sign is put back.
    assign prod       = i_gain * i_mag;
    assign o_term_mag = prod[pwgi_pkg::Q_FRAC +: pwgi_pkg::TERM_W];

endmodule

// ===== rtl/core/pwgi_ctrl.sv =====
// Sequencer that steps the shared multiplier through the P, D and I terms.
// Depends on pwgi_pkg for the state and control types.
module pwgi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    output pwgi_pkg::t_ctrl   o_ctl
);

    pwgi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwgi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_ctl.op       = pwgi_pkg::OP_P;
        case (r_state)
            pwgi_pkg::ST_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_start) begin
                    n_state = pwgi_pkg::ST_PTERM;
                end
            end
            pwgi_pkg::ST_PTERM: begin
                o_ctl.op     = pwgi_pkg::OP_P;
                o_ctl.load_p = 1'b1;
                n_state      = pwgi_pkg::ST_DTERM;
            end
            pwgi_pkg::ST_DTERM: begin
                o_ctl.op     = pwgi_pkg::OP_D;
                o_ctl.load_d = 1'b1;
                n_state      = pwgi_pkg::ST_ITERM;
            end
            pwgi_pkg::ST_ITERM: begin
                o_ctl.op     = pwgi_pkg::OP_I;
                o_ctl.load_i = 1'b1;
                n_state      = pwgi_pkg::ST_SUM;
            end
            pwgi_pkg::ST_SUM: begin
                if (i_out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = pwgi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pwgi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/pid_with_gated_integral.sv =====
// Top level of the PID controller with gated, clamped integral and settle flag.
// Depends on pwgi_pkg, pwgi_mul and pwgi_ctrl.

// Each input word carries a signed measurement, a free-running millisecond
// timestamp and a restart bit, and produces exactly one output word: the
// drive value P + I + D saturated to signed 32 bits, and an arrived flag.
// Error is target minus measurement; the gains are unsigned Q8.8 and each
// term is the exact product scaled by 1/256, truncated toward zero. The
// integral is held at zero while |P| is at least i_range, otherwise it
// accumulates the error and is clamped to +/- int_limit; it is also cleared
// when its sign differs from the error or the error is within the error band.
// The first word after reset, or a word with restart set, gives a zero
// derivative and starts from a cleared integral. Arrived goes high once the
// error and |D| have both stayed in tolerance for SETTLE_MS milliseconds.
// Each word passes the accept step in the idle state, then the P, D and I
// states through the single shared 16 x 21 multiplier, then the sum state,
// which sums, saturates and loads the output, waiting while it is stalled.
// The input stall is high from the P state until the output is loaded. A
// finished word waits in the output register, and the next input word can
// be taken while it is still held there. Configuration writes are taken at
// any cycle but should only be issued while the block is idle.
module pid_with_gated_integral #(
    parameter int SETTLE_MS = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [pwgi_pkg::CFG_W-1:0] i_cfg_data,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [15:0] i_measurement,
    input  logic [31:0] i_now_ms,
    input  logic        i_restart,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_drive,
    output logic        o_arrived
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [15:0] r_target;
    logic [15:0]        r_gain_p, r_gain_i, r_gain_d;
    logic [19:0]        r_int_limit;
    logic [23:0]        r_i_range;
    logic [15:0]        r_err_band;
    logic [23:0]        r_d_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_limit <= 20'hFFFFF;
            r_i_range   <= 24'd50;
            r_err_band  <= '0;
            r_d_tol     <= 24'd10;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pwgi_pkg::REG_TARGET:    r_target    <= i_cfg_data[15:0];
                pwgi_pkg::REG_GAIN_P:    r_gain_p    <= i_cfg_data[15:0];
                pwgi_pkg::REG_GAIN_I:    r_gain_i    <= i_cfg_data[15:0];
                pwgi_pkg::REG_GAIN_D:    r_gain_d    <= i_cfg_data[15:0];
                pwgi_pkg::REG_INT_LIMIT: r_int_limit <= i_cfg_data[19:0];
                pwgi_pkg::REG_I_RANGE:   r_i_range   <= i_cfg_data[23:0];
                pwgi_pkg::REG_ERR_BAND:  r_err_band  <= i_cfg_data[15:0];
                pwgi_pkg::REG_D_TOL:     r_d_tol     <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and shared multiplier.
    // ------------------------------------------------------------------
    pwgi_pkg::t_ctrl ctl;
    logic            in_acc;
    logic            out_free;

    assign in_acc     = i_in_valid && ctl.ready;
    assign o_in_stall = !ctl.ready;
    assign out_free   = !o_out_valid || !i_out_stall;

    pwgi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    // Working registers of one word.
    logic signed [16:0] r_err;
    logic signed [17:0] r_deriv;
    logic [31:0]        r_now;
    logic               r_restart;

    // Persistent controller state.
    logic               r_first;
    logic signed [16:0] r_prev;
    logic signed [20:0] r_acc;
    logic [31:0]        r_settle_start;
    logic               r_arrived;

    // Term magnitudes and signs.
    logic [pwgi_pkg::TERM_W-1:0] r_p_mag, r_d_mag, r_i_mag;
    logic                        r_p_neg, r_d_neg, r_i_neg;

    logic [21:0]                 err_mag;
    logic [pwgi_pkg::OPND_W-1:0] opnd_abs;
    logic                        opnd_neg;
    logic [pwgi_pkg::GAIN_W-1:0] mul_gain;
    logic [pwgi_pkg::TERM_W-1:0] mul_mag;

    assign err_mag = pwgi_pkg::abs22(22'(r_err));

    always_comb begin
        case (ctl.op)
            pwgi_pkg::OP_P: begin
                mul_gain = r_gain_p;
                opnd_abs = err_mag[pwgi_pkg::OPND_W-1:0];
                opnd_neg = r_err[16];
            end
            pwgi_pkg::OP_D: begin
                mul_gain = r_gain_d;
                opnd_abs = pwgi_pkg::OPND_W'(pwgi_pkg::abs22(22'(r_deriv)));
                opnd_neg = r_deriv[17];
            end
            pwgi_pkg::OP_I: begin
                mul_gain = r_gain_i;
                opnd_abs = pwgi_pkg::OPND_W'(pwgi_pkg::abs22(22'(r_acc)));
                opnd_neg = r_acc[20];
            end
            default: begin
                mul_gain = '0;
                opnd_abs = '0;
                opnd_neg = 1'b0;
            end
        endcase
    end

    pwgi_mul u_mul (
        .i_gain     (mul_gain),
        .i_mag      (opnd_abs),
        .o_term_mag (mul_mag)
    );

    // ------------------------------------------------------------------
    // Integral update, evaluated while D is being formed (P is ready).
    // ------------------------------------------------------------------
    logic signed [21:0] acc_sum, acc_clamp, acc_gate;
    logic [21:0]        acc_sum_mag;
    logic               sign_differs;
    logic               err_in_tol;
    logic               d_in_tol;

    assign err_in_tol = err_mag <= 22'(r_err_band);

    always_comb begin
        acc_sum     = 22'(r_acc) + 22'(r_err);
        acc_sum_mag = pwgi_pkg::abs22(acc_sum);
        if (acc_sum_mag > 22'(r_int_limit)) begin
            acc_clamp = acc_sum[21] ? -$signed(22'(r_int_limit))
                                    : $signed(22'(r_int_limit));
        end else begin
            acc_clamp = acc_sum;
        end
        // Integration is gated off while the proportional term is large.
        if (r_p_mag >= pwgi_pkg::TERM_W'(r_i_range)) begin
            acc_gate = '0;
        end else begin
            acc_gate = acc_clamp;
        end
        // Zero has a sign of its own, so compare both negativity and zeroness.
        sign_differs = (acc_gate[21] != r_err[16])
                    || ((acc_gate == '0) != (r_err == '0));
    end

    assign d_in_tol = 24'(r_d_mag) <= r_d_tol && r_d_mag[28:24] == '0;

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    logic signed [16:0] prev_eff;
    assign prev_eff = (r_first || r_restart) ? r_err : r_prev;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err     <= 17'(r_target) - 17'(i_measurement);
            r_now     <= i_now_ms;
            r_restart <= i_restart;
        end
        if (ctl.load_p) begin
            r_p_mag <= mul_mag;
            r_p_neg <= opnd_neg;
            r_deriv <= 18'(r_err) - 18'(prev_eff);
        end
        if (ctl.load_d) begin
            r_d_mag <= mul_mag;
            r_d_neg <= opnd_neg;
        end
        if (ctl.load_i) begin
            r_i_mag <= mul_mag;
            r_i_neg <= opnd_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first        <= 1'b1;
            r_prev         <= '0;
            r_acc          <= '0;
            r_settle_start <= '0;
            r_arrived      <= 1'b0;
        end else begin
            if (ctl.load_p) begin
                r_first <= 1'b0;
                r_prev  <= r_err;
                if (r_first || r_restart) begin
                    r_acc <= '0;
                end
            end
            if (ctl.load_d) begin
                if (sign_differs || err_in_tol) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_gate[20:0];
                end
            end
            // The settle timer looks at the freshly formed D term.
            if (ctl.load_i) begin
                if (err_in_tol && d_in_tol) begin
                    if ((r_now - r_settle_start) >= 32'(SETTLE_MS)) begin
                        r_arrived <= 1'b1;
                    end
                end else begin
                    r_settle_start <= r_now;
                    r_arrived      <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum, saturation and output register.
    // ------------------------------------------------------------------
    logic signed [32:0] p_s, i_s, d_s, sum;
    logic signed [31:0] sum_sat;

    always_comb begin
        p_s = r_p_neg ? -$signed(33'(r_p_mag)) : $signed(33'(r_p_mag));
        i_s = r_i_neg ? -$signed(33'(r_i_mag)) : $signed(33'(r_i_mag));
        d_s = r_d_neg ? -$signed(33'(r_d_mag)) : $signed(33'(r_d_mag));
        sum = p_s + i_s + d_s;
        if (sum > 33'sh0_7FFF_FFFF) begin
            sum_sat = 32'sh7FFF_FFFF;
        end else if (sum < -33'sh0_8000_0000) begin
            sum_sat = 32'sh8000_0000;
        end else begin
            sum_sat = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (ctl.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            o_drive   <= sum_sat;
            o_arrived <= r_arrived;
        end
    end

`ifndef SYNTHESIS
    // An accepted word keeps the input side stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // Forming the P term always retires the first-update condition.
    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load_p |=> !r_first)
        else $error("first-update flag still set after P term");

    // A finished word is presented on the output in the next cycle.
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load_out |=> o_out_valid)
        else $error("output valid missing after load");

    // The sequencer only loads the output when the register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule
